// ===== sv/binary_min_heap_engine_defines.svh =====
// Assertion macros for the heap engine RTL.
`ifndef BINARY_MIN_HEAP_ENGINE_DEFINES_SVH
`define BINARY_MIN_HEAP_ENGINE_DEFINES_SVH

// Same-cycle implication, checked on clk, off while rst_n is low.
`define BMH_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked on clk, off while rst_n is low.
`define BMH_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== sv/bmh_pkg.sv =====
// Shared types and defaults for the binary min-heap engine.
`timescale 1ns / 1ps
package bmh_pkg;

    localparam int CAPACITY_DEF  = 256;
    localparam int KEY_WIDTH_DEF = 16;
    localparam int TAG_WIDTH_DEF = 16;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_RM_RD,
        S_RM_LD,
        S_DN_RD,
        S_DN_CMP,
        S_PUT,
        S_RESP
    } state_t;

    // Response handed from the sequencer to the output register.
    typedef struct packed
    {
        logic    valid;
        status_t status;
    } rsp_t;

endpackage

// ===== sv/binary_min_heap_engine.sv =====
// Top level of the binary min-heap priority queue engine.
`timescale 1ns / 1ps
//
//  channel   dir  beat fields (low bit first)
//  s_axis    in   tuser: opcode; tdata: key, tag, zero pad
//  m_axis    out  tuser: status; tdata: out_key, out_tag, fill_count, zero pad
//
//  One item at a time. Insert: into an empty heap the entry is written straight to the root;
//  else it is read and compared against each parent in turn, with a final write when it lands
//  at the root. Remove: reads the root and the last live entry, skips the sift-down when it took
//  the only entry, else sifts down level by level. The result is held in the output register.
//  Each level costs one read/compare round trip through the single entry memory.
//  Reset clears the count and control; heap entries are never cleared.
//  A finished beat sits in the output register; the next item is taken while it waits,
//  and a full output register with tready low stalls only the end of that item.
//
module binary_min_heap_engine
    import bmh_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF,
    parameter int TAG_WIDTH = TAG_WIDTH_DEF,
    parameter int AW        = $clog2(CAPACITY),
    parameter int CW        = $clog2(CAPACITY + 1),
    parameter int IDW       = ((KEY_WIDTH + TAG_WIDTH + 7) / 8) * 8,
    parameter int ODW       = ((KEY_WIDTH + TAG_WIDTH + CW + 7) / 8) * 8
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [IDW-1:0] s_axis_tdata,   // key, tag, zero pad
    input  logic           s_axis_tuser,   // opcode
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [ODW-1:0] m_axis_tdata,   // out_key, out_tag, fill_count, zero pad
    output logic [1:0]     m_axis_tuser    // status
);

    localparam int DW = KEY_WIDTH + TAG_WIDTH;

    rsp_t                 rsp;
    logic                 out_free;
    logic [KEY_WIDTH-1:0] rsp_key;
    logic [TAG_WIDTH-1:0] rsp_tag;
    logic [CW-1:0]        rsp_count;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [DW-1:0]        mem_wdata;
    logic [AW-1:0]        mem_raddr_a;
    logic [AW-1:0]        mem_raddr_b;
    logic [DW-1:0]        mem_rdata_a;
    logic [DW-1:0]        mem_rdata_b;

    logic                 ovalid_reg;
    logic [KEY_WIDTH-1:0] okey_reg;
    logic [TAG_WIDTH-1:0] otag_reg;
    logic [CW-1:0]        ocount_reg;
    status_t              ost_reg;

    // output register frees up in the same cycle the sink takes its beat
    assign out_free = !ovalid_reg || m_axis_tready;

    bmh_ctrl #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH),
        .TAG_WIDTH (TAG_WIDTH),
        .AW        (AW),
        .CW        (CW),
        .DW        (DW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_op       (op_t'(s_axis_tuser)),
        .in_key      (s_axis_tdata[KEY_WIDTH-1:0]),
        .in_tag      (s_axis_tdata[DW-1:KEY_WIDTH]),
        .out_free    (out_free),
        .rsp         (rsp),
        .rsp_key     (rsp_key),
        .rsp_tag     (rsp_tag),
        .rsp_count   (rsp_count),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr_a (mem_raddr_a),
        .mem_raddr_b (mem_raddr_b),
        .mem_rdata_a (mem_rdata_a),
        .mem_rdata_b (mem_rdata_b)
    );

    bmh_store #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .DW    (DW)
    ) u_store (
        .clk       (clk),
        .wr_en     (mem_we),
        .wr_addr   (mem_waddr),
        .wr_data   (mem_wdata),
        .rd_addr_a (mem_raddr_a),
        .rd_addr_b (mem_raddr_b),
        .rd_data_a (mem_rdata_a),
        .rd_data_b (mem_rdata_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (rsp.valid)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp.valid)
        begin
            okey_reg   <= rsp_key;
            otag_reg   <= rsp_tag;
            ocount_reg <= rsp_count;
            ost_reg    <= rsp.status;
        end
    end

    always_comb
    begin
        m_axis_tdata                             = '0;
        m_axis_tdata[KEY_WIDTH-1:0]              = okey_reg;
        m_axis_tdata[DW-1:KEY_WIDTH]             = otag_reg;
        m_axis_tdata[DW+CW-1:DW]                 = ocount_reg;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tuser  = ost_reg;

endmodule

// ===== sv/bmh_store.sv =====
// Heap entry memory: one write port, two registered read ports.
`timescale 1ns / 1ps
module bmh_store
    import bmh_pkg::*;
#(
    parameter int DEPTH = CAPACITY_DEF,
    parameter int AW    = $clog2(CAPACITY_DEF),
    parameter int DW    = KEY_WIDTH_DEF + TAG_WIDTH_DEF
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr_a,
    input  logic [AW-1:0] rd_addr_b,
    output logic [DW-1:0] rd_data_a,
    output logic [DW-1:0] rd_data_b
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ===== sv/bmh_ctrl.sv =====
// Heap sequencer: insert with sift-up, remove-min with sift-down.
`timescale 1ns / 1ps
`include "binary_min_heap_engine_defines.svh"
module bmh_ctrl
    import bmh_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF,
    parameter int TAG_WIDTH = TAG_WIDTH_DEF,
    parameter int AW        = $clog2(CAPACITY),
    parameter int CW        = $clog2(CAPACITY + 1),
    parameter int DW        = KEY_WIDTH + TAG_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  op_t                  in_op,
    input  logic [KEY_WIDTH-1:0] in_key,
    input  logic [TAG_WIDTH-1:0] in_tag,
    input  logic                 out_free,
    output rsp_t                 rsp,
    output logic [KEY_WIDTH-1:0] rsp_key,
    output logic [TAG_WIDTH-1:0] rsp_tag,
    output logic [CW-1:0]        rsp_count,
    output logic                 mem_we,
    output logic [AW-1:0]        mem_waddr,
    output logic [DW-1:0]        mem_wdata,
    output logic [AW-1:0]        mem_raddr_a,
    output logic [AW-1:0]        mem_raddr_b,
    input  logic [DW-1:0]        mem_rdata_a,
    input  logic [DW-1:0]        mem_rdata_b
);

    localparam int XW = AW + 2;

    state_t               state_reg,   state_next;
    logic [CW-1:0]        count_reg,   count_next;
    logic [AW-1:0]        pos_reg,     pos_next;
    logic [DW-1:0]        mov_reg,     mov_next;
    logic [KEY_WIDTH-1:0] res_key_reg, res_key_next;
    logic [TAG_WIDTH-1:0] res_tag_reg, res_tag_next;
    status_t              res_st_reg,  res_st_next;

    logic                 accept;
    logic                 full;
    logic [AW-1:0]        parent;
    logic [AW:0]          lc;
    logic [AW:0]          rc;
    logic                 lc_in;
    logic                 rc_in;
    logic                 up_swap;
    logic                 pick_r;
    logic [DW-1:0]        pick_d;
    logic                 dn_swap;

    assign accept = in_valid && in_ready;
    assign full   = (count_reg == CW'(CAPACITY));
    assign parent = AW'((pos_reg - AW'(1)) >> 1);
    assign lc     = {pos_reg, 1'b1};
    assign rc     = lc + (AW + 1)'(1);
    assign lc_in  = (XW'(lc) < XW'(count_reg));
    assign rc_in  = (XW'(rc) < XW'(count_reg));

    // key sits in the low bits of an entry
    assign up_swap = (mov_reg[KEY_WIDTH-1:0] < mem_rdata_a[KEY_WIDTH-1:0]);
    assign pick_r  = rc_in && (mem_rdata_b[KEY_WIDTH-1:0] < mem_rdata_a[KEY_WIDTH-1:0]);
    assign pick_d  = pick_r ? mem_rdata_b : mem_rdata_a;
    assign dn_swap = (mov_reg[KEY_WIDTH-1:0] > pick_d[KEY_WIDTH-1:0]);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        mov_next     = mov_reg;
        res_key_next = res_key_reg;
        res_tag_next = res_tag_reg;
        res_st_next  = res_st_reg;
        in_ready     = 1'b0;
        rsp.valid    = 1'b0;
        rsp.status   = res_st_reg;
        mem_we       = 1'b0;
        mem_waddr    = pos_reg;
        mem_wdata    = mov_reg;
        mem_raddr_a  = parent;
        mem_raddr_b  = rc[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    res_key_next = '0;
                    res_tag_next = '0;
                    res_st_next  = ST_DONE;
                    if (in_op == OP_INSERT)
                    begin
                        if (full)
                        begin
                            res_st_next = ST_FULL;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            pos_next   = count_reg[AW-1:0];
                            mov_next   = {in_tag, in_key};
                            count_next = count_reg + CW'(1);
                            state_next = (count_reg == '0) ? S_PUT : S_UP_RD;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_st_next = ST_EMPTY;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                            state_next = S_RM_RD;
                        end
                    end
                end
            end

            S_UP_RD:
            begin
                mem_raddr_a = parent;
                state_next  = S_UP_CMP;
            end

            S_UP_CMP:
            begin
                mem_we = 1'b1;
                if (up_swap)
                begin
                    mem_wdata  = mem_rdata_a;
                    pos_next   = parent;
                    state_next = (parent == '0) ? S_PUT : S_UP_RD;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end

            S_RM_RD:
            begin
                // root and the last live entry, count already decremented
                mem_raddr_a = '0;
                mem_raddr_b = count_reg[AW-1:0];
                state_next  = S_RM_LD;
            end

            S_RM_LD:
            begin
                res_key_next = mem_rdata_a[KEY_WIDTH-1:0];
                res_tag_next = mem_rdata_a[DW-1:KEY_WIDTH];
                mov_next     = mem_rdata_b;
                pos_next     = '0;
                state_next   = (count_reg == '0) ? S_RESP : S_DN_RD;
            end

            S_DN_RD:
            begin
                mem_raddr_a = lc[AW-1:0];
                mem_raddr_b = rc[AW-1:0];
                state_next  = lc_in ? S_DN_CMP : S_PUT;
            end

            S_DN_CMP:
            begin
                mem_we = 1'b1;
                if (dn_swap)
                begin
                    mem_wdata  = pick_d;
                    pos_next   = pick_r ? rc[AW-1:0] : lc[AW-1:0];
                    state_next = S_DN_RD;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end

            S_PUT:
            begin
                mem_we     = 1'b1;
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    rsp.valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        mov_reg     <= mov_next;
        res_key_reg <= res_key_next;
        res_tag_reg <= res_tag_next;
        res_st_reg  <= res_st_next;
    end

    assign rsp_key   = res_key_reg;
    assign rsp_tag   = res_tag_reg;
    assign rsp_count = count_reg;

    `BMH_ASSERT_NOW(a_count_cap, 1'b1, count_reg <= CW'(CAPACITY), "entry count above capacity")
    `BMH_ASSERT_NOW(a_write_live, mem_we, XW'(mem_waddr) < XW'(count_reg), "write outside live entries")
    `BMH_ASSERT_NEXT(a_full_hold, accept && (in_op == OP_INSERT) && full, $stable(count_reg), "refused insert changed count")
    `BMH_ASSERT_NEXT(a_up_climbs, (state_reg == S_UP_CMP) && up_swap, pos_reg < $past(pos_reg), "sift-up did not climb")

endmodule

// ===== tb/tb.sv =====
// Self-checking stream testbench for the binary min-heap engine.
`timescale 1ns / 1ps
module tb;
    import bmh_pkg::*;

    localparam int HEAP_SLOTS     = CAPACITY_DEF;
    localparam int TAIL_ITEMS     = 200;   // last beats run with no idling
    localparam int DRAIN_CYCLES   = 40;    // longer than the slowest remove
    localparam int WATCHDOG_LIMIT = 5000;  // cycles without any accepted beat
    localparam int MAX_REPORTS    = 10;

    typedef struct packed
    {
        op_t         op;
        logic [15:0] key;
        logic [15:0] tag;
    } heap_req_t;

    typedef struct packed
    {
        logic [15:0] key;
        logic [15:0] tag;
        status_t     status;
        logic [8:0]  fill;
    } heap_beat_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // key, tag
    logic        s_axis_tuser;   // opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // out_key, out_tag, fill_count, zero pad
    logic [1:0]  m_axis_tuser;   // status

    heap_req_t  pending_reqs[$];
    heap_beat_t expected_beats[$];
    heap_req_t  req_on_bus;

    // Shadow heap kept in step with the engine
    logic [15:0] shadow_key[HEAP_SLOTS];
    logic [15:0] shadow_tag[HEAP_SLOTS];
    int          shadow_count;

    int   mismatch_count;
    int   quiet_cycles;
    logic tail_quiet;
    int   src_gap, src_idle_pct, src_beats;
    int   sink_stall, sink_idle_pct, sink_beats;

    binary_min_heap_engine u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Apply one request to the shadow heap and return the beat it should produce.
    function automatic heap_beat_t heap_apply(heap_req_t req);
        heap_beat_t  r;
        int          pos, up, lc, rc, pick;
        logic [15:0] mk, mt;
        logic        settled;
        r.key    = '0;
        r.tag    = '0;
        r.status = ST_DONE;
        if (req.op == OP_INSERT)
        begin
            if (shadow_count >= HEAP_SLOTS)
                r.status = ST_FULL;
            else
            begin
                // sift up while strictly smaller than the parent
                pos     = shadow_count;
                mk      = req.key;
                mt      = req.tag;
                settled = 1'b0;
                while (pos > 0 && !settled)
                begin
                    up = (pos - 1) / 2;
                    if (mk < shadow_key[up])
                    begin
                        shadow_key[pos] = shadow_key[up];
                        shadow_tag[pos] = shadow_tag[up];
                        pos = up;
                    end
                    else
                        settled = 1'b1;
                end
                shadow_key[pos] = mk;
                shadow_tag[pos] = mt;
                shadow_count++;
            end
        end
        else if (shadow_count == 0)
            r.status = ST_EMPTY;
        else
        begin
            r.key = shadow_key[0];
            r.tag = shadow_tag[0];
            shadow_count--;
            if (shadow_count > 0)
            begin
                // last entry to the root, then sift down; left child wins ties
                mk      = shadow_key[shadow_count];
                mt      = shadow_tag[shadow_count];
                pos     = 0;
                settled = 1'b0;
                while (!settled)
                begin
                    lc = 2 * pos + 1;
                    rc = lc + 1;
                    if (lc >= shadow_count)
                        settled = 1'b1;
                    else
                    begin
                        pick = lc;
                        if (rc < shadow_count && shadow_key[rc] < shadow_key[lc])
                            pick = rc;
                        if (mk > shadow_key[pick])
                        begin
                            shadow_key[pos] = shadow_key[pick];
                            shadow_tag[pos] = shadow_tag[pick];
                            pos = pick;
                        end
                        else
                            settled = 1'b1;
                    end
                end
                shadow_key[pos] = mk;
                shadow_tag[pos] = mt;
            end
        end
        r.fill = shadow_count[8:0];
        return r;
    endfunction

    function automatic heap_req_t make_req(op_t op, logic [15:0] key, logic [15:0] tag);
        heap_req_t r;
        r.op  = op;
        r.key = key;
        r.tag = tag;
        return r;
    endfunction

    // Keys are mostly full range; a share is packed tight to force ties.
    function automatic logic [15:0] pick_key();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60)
            return 16'($urandom_range(16'hFFFF));
        else if (sel < 90)
            return 16'($urandom_range(15));
        else if (sel < 95)
            return 16'h0000;
        else
            return 16'hFFFF;
    endfunction

    task automatic check_result_beat(heap_beat_t got);
        heap_beat_t want;
        if (expected_beats.size() == 0)
        begin
            if (mismatch_count < MAX_REPORTS)
                $display("unexpected result beat: key %h tag %h status %0d fill %0d",
                         got.key, got.tag, got.status, got.fill);
            mismatch_count++;
        end
        else
        begin
            want = expected_beats.pop_front();
            if (got.key !== want.key || got.tag !== want.tag ||
                got.status !== want.status || got.fill !== want.fill)
            begin
                if (mismatch_count < MAX_REPORTS)
                    $display("result mismatch: exp key %h tag %h status %0d fill %0d, got key %h tag %h status %0d fill %0d",
                             want.key, want.tag, want.status, want.fill,
                             got.key, got.tag, got.status, got.fill);
                mismatch_count++;
            end
        end
    endtask

    // Source side: one beat in flight, random gaps between beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
            src_gap       <= 0;
            src_idle_pct  <= 0;
            src_beats     <= 0;
            tail_quiet    <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_beats.push_back(heap_apply(req_on_bus));
            tail_quiet <= (pending_reqs.size() <= TAIL_ITEMS);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap       <= src_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    req_on_bus = pending_reqs.pop_front();
                    s_axis_tdata  <= {req_on_bus.tag, req_on_bus.key};
                    s_axis_tuser  <= req_on_bus.op;
                    s_axis_tvalid <= 1'b1;
                    if (!tail_quiet && $urandom_range(99) < src_idle_pct)
                        src_gap <= $urandom_range(13, 1);
                    src_beats <= src_beats + 1;
                    if (src_beats % 64 == 0)
                    begin
                        case ($urandom_range(2))
                            0: src_idle_pct <= 0;
                            1: src_idle_pct <= 15;
                            default: src_idle_pct <= 50;
                        endcase
                    end
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Sink side: check each result beat, stall in bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_stall    <= 0;
            sink_idle_pct <= 0;
            sink_beats    <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_result_beat({m_axis_tdata[15:0], m_axis_tdata[31:16],
                                   status_t'(m_axis_tuser), m_axis_tdata[40:32]});
                sink_beats <= sink_beats + 1;
                if (sink_beats % 32 == 0)
                begin
                    case ($urandom_range(2))
                        0: sink_idle_pct <= 0;
                        1: sink_idle_pct <= 5;
                        default: sink_idle_pct <= 20;
                    endcase
                end
            end
            if (sink_stall > 0)
            begin
                sink_stall    <= sink_stall - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!tail_quiet && $urandom_range(99) < sink_idle_pct)
            begin
                sink_stall    <= $urandom_range(12, 0);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int   i, ph, ins_pct, n, approx;
        op_t  op;
        rst_n          = 1'b0;
        shadow_count   = 0;
        mismatch_count = 0;

        // Directed: empty remove, field extremes, equal keys, drain, empty again
        pending_reqs.push_back(make_req(OP_REMOVE, 16'h1234, 16'h5678));
        pending_reqs.push_back(make_req(OP_INSERT, 16'hFFFF, 16'hFFFF));
        pending_reqs.push_back(make_req(OP_INSERT, 16'h0000, 16'h0000));
        pending_reqs.push_back(make_req(OP_INSERT, 16'h8000, 16'h0001));
        pending_reqs.push_back(make_req(OP_INSERT, 16'h0001, 16'h8000));
        pending_reqs.push_back(make_req(OP_INSERT, 16'h5555, 16'hAAAA));
        pending_reqs.push_back(make_req(OP_INSERT, 16'hAAAA, 16'h5555));
        for (i = 1; i <= 4; i++)
            pending_reqs.push_back(make_req(OP_INSERT, 16'h0100, 16'(i)));
        for (i = 0; i < 10; i++)
            pending_reqs.push_back(make_req(OP_REMOVE, 16'hFFFF, 16'hFFFF));
        pending_reqs.push_back(make_req(OP_REMOVE, 16'h0000, 16'h0000));

        // Random: mixed, fill past full, drain past empty, mixed again
        approx = 0;
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin ins_pct = 55; n = 300; end
                1: begin ins_pct = 90; n = 400; end
                2: begin ins_pct = 10; n = 400; end
                default: begin ins_pct = 60; n = 400; end
            endcase
            for (i = 0; i < n; i++)
            begin
                op = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_REMOVE;
                pending_reqs.push_back(make_req(op, pick_key(),
                                                16'($urandom_range(16'hFFFF))));
                if (op == OP_INSERT && approx < HEAP_SLOTS)
                    approx++;
                else if (op == OP_REMOVE && approx > 0)
                    approx--;
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_beats.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
